// ===== hdl/dor4_pkg.sv =====
package dor4_pkg;

  // Widths of the port fields.
  localparam int ID_W    = 16;
  localparam int IDX_W   = 3;
  localparam int SIDE_W  = 5;
  localparam int MAX_HOPS = 5;

  // Width of the power table entries (side to the fourth reaches 65536).
  localparam int POW_W   = 17;
  localparam int RECIP_W = 16;
  // Fixed point scale of the reciprocals.
  localparam int RECIP_SHIFT = 16;

  localparam logic [SIDE_W-1:0] SIDE_MIN   = 5'd2;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = 5'd16;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd6;

  localparam int TAB_DEPTH = 17;

  // Powers of the side length, indexed [exponent - 1][side]. Entries below the
  // smallest side are never selected once the side has been saturated.
  localparam logic [POW_W-1:0] POW_TAB [4][TAB_DEPTH] = '{
    '{2, 2, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16},
    '{4, 4, 4, 9, 16, 25, 36, 49, 64, 81, 100, 121, 144, 169, 196, 225, 256},
    '{8, 8, 8, 27, 64, 125, 216, 343, 512, 729, 1000, 1331, 1728, 2197, 2744,
      3375, 4096},
    '{16, 16, 16, 81, 256, 625, 1296, 2401, 4096, 6561, 10000, 14641, 20736,
      28561, 38416, 50625, 65536}
  };

  // Truncated reciprocals of the first three powers, scaled by 2^16.
  localparam logic [RECIP_W-1:0] RECIP_TAB [3][TAB_DEPTH] = '{
    '{32768, 32768, 32768, 21845, 16384, 13107, 10922, 9362, 8192, 7281, 6553,
      5957, 5461, 5041, 4681, 4369, 4096},
    '{16384, 16384, 16384, 7281, 4096, 2621, 1820, 1337, 1024, 809, 655, 541,
      455, 387, 334, 291, 256},
    '{8192, 8192, 8192, 2427, 1024, 524, 303, 191, 128, 89, 65, 49, 37, 29, 23,
      19, 16}
  };

  typedef struct packed {
    logic [ID_W-1:0] source_node;
    logic [ID_W-1:0] dest_node;
  } route_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  hop_node;
    logic [IDX_W-1:0] hop_index;
    logic             last_hop;
    logic             bad_id;
  } route_hop_t;

  // Control handed from the arithmetic pipeline to the hop serialiser.
  typedef struct packed {
    logic                valid;
    logic                bad;
    logic [MAX_HOPS-1:0] hops;
  } route_ctl_t;

  function automatic logic [SIDE_W-1:0] side_sat(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] s;
    s = v;
    if (v < SIDE_MIN) begin
      s = SIDE_MIN;
    end else if (v > SIDE_MAX) begin
      s = SIDE_MAX;
    end
    return s;
  endfunction

endpackage

// ===== hdl/dimension_order_route_4d_unit.sv =====
// Dimension-order route generator for a four-dimensional network that is fully
// connected along each axis. A request beat on the in_ channel carries a source
// and a destination id; the out_ channel returns the path one beat per hop:
// first the source, then one node for each of X, Y, Z, W whose digit differs,
// the final beat flagged last_hop. An id not below side^4 (or wider than
// NODE_BITS) gives a single beat with bad_id set and a zero node.
// The side length is written through cfg_wr_en / cfg_wr_data while the block
// is idle; values outside 2..16 saturate. Reset sets it to 6 and empties the
// pipeline.
// A request beat passes the input register, three divide stages, the hop
// serialiser and the output register in that order. The hop serialiser sends
// one beat per hop of a request and takes the next request as the last hop of
// the current one moves into the output register.
// When the receiver holds out_ready low the output register keeps its beat and
// the serialiser waits; requests behind it move up until one reaches the end
// of the pipeline, after which the pipeline freezes with in_ready low. No beat
// is lost or repeated.
module dimension_order_route_4d_unit #(
  parameter int NODE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dor4_pkg::route_req_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dor4_pkg::route_hop_t              out_data,
  input  logic                              cfg_wr_en,
  input  logic [dor4_pkg::SIDE_W-1:0]       cfg_wr_data
);

  localparam int HOPS   = dor4_pkg::MAX_HOPS;
  localparam int STAGES = 4;

  logic [dor4_pkg::SIDE_W-1:0]  side_nxt;
  logic [dor4_pkg::POW_W-1:0]   mod_r [3];
  logic [dor4_pkg::RECIP_W-1:0] recip_r [3];
  logic [dor4_pkg::POW_W-1:0]   limit_r;

  logic                  en, in_bad, ser_ready;
  logic [STAGES-1:0]     v_r, bad_r;
  logic [NODE_BITS-1:0]  src_r [STAGES];
  logic [NODE_BITS-1:0]  dst_r [STAGES];
  logic [NODE_BITS-1:0]  rs [3];
  logic [NODE_BITS-1:0]  rd [3];
  logic [NODE_BITS-1:0]  cand [HOPS];
  dor4_pkg::route_ctl_t  ctl;

  // The powers and reciprocals are taken from the tables when the side length
  // is written, so the datapath sees them as constants.
  assign side_nxt = dor4_pkg::side_sat(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        mod_r[j]   <= dor4_pkg::POW_TAB[j][dor4_pkg::SIDE_RESET];
        recip_r[j] <= dor4_pkg::RECIP_TAB[j][dor4_pkg::SIDE_RESET];
      end
      limit_r <= dor4_pkg::POW_TAB[3][dor4_pkg::SIDE_RESET];
    end else if (cfg_wr_en) begin
      for (int j = 0; j < 3; j++) begin
        mod_r[j]   <= dor4_pkg::POW_TAB[j][side_nxt];
        recip_r[j] <= dor4_pkg::RECIP_TAB[j][side_nxt];
      end
      limit_r <= dor4_pkg::POW_TAB[3][side_nxt];
    end
  end

  assign en       = !v_r[STAGES-1] || ser_ready;
  assign in_ready = en;

  assign in_bad = (dor4_pkg::POW_W'(in_data.source_node) >= limit_r)
               || (dor4_pkg::POW_W'(in_data.dest_node) >= limit_r)
               || ((in_data.source_node >> NODE_BITS) != '0)
               || ((in_data.dest_node >> NODE_BITS) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_r[0] <= in_data.source_node[NODE_BITS-1:0];
      dst_r[0] <= in_data.dest_node[NODE_BITS-1:0];
      bad_r    <= {bad_r[STAGES-2:0], in_bad};
      for (int k = 1; k < STAGES; k++) begin
        src_r[k] <= src_r[k-1];
        dst_r[k] <= dst_r[k-1];
      end
    end
  end

  // Remainders of both ids modulo side, side^2 and side^3.
  for (genvar j = 0; j < 3; j++) begin : g_div
    dor4_divmod #(.NODE_BITS(NODE_BITS)) u_src_div (
      .clk     (clk),
      .en      (en),
      .x_i     (src_r[0]),
      .recip_i (recip_r[j]),
      .mod_i   (mod_r[j]),
      .rem_o   (rs[j])
    );
    dor4_divmod #(.NODE_BITS(NODE_BITS)) u_dst_div (
      .clk     (clk),
      .en      (en),
      .x_i     (dst_r[0]),
      .recip_i (recip_r[j]),
      .mod_i   (mod_r[j]),
      .rem_o   (rd[j])
    );
  end

  // After the leading dimensions have been corrected, a node takes the upper
  // digits from the destination and the lower ones from the source. A hop is
  // only emitted where this changes the node, i.e. where the digits differed.
  always_comb begin
    cand[0] = src_r[STAGES-1];
    for (int k = 1; k < HOPS - 1; k++) begin
      cand[k] = dst_r[STAGES-1] - rd[3-k] + rs[3-k];
    end
    cand[HOPS-1] = dst_r[STAGES-1];
    ctl.valid   = v_r[STAGES-1];
    ctl.bad     = bad_r[STAGES-1];
    ctl.hops[0] = 1'b1;
    for (int k = 1; k < HOPS; k++) begin
      ctl.hops[k] = (cand[k] != cand[k-1]);
    end
  end

  dor4_serial #(.NODE_BITS(NODE_BITS)) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .nodes_i   (cand),
    .ready_o   (ser_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_bad_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_id) |->
      (out_data.last_hop && out_data.hop_index == '0 && out_data.hop_node == '0))
    else $error("bad id beat is not a lone zero hop");

  a_path_continues : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_hop) |=>
      (out_valid && out_data.hop_index == $past(out_data.hop_index) + 3'd1))
    else $error("path broken after a non-final hop");

  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hop_index <= 3'd4))
    else $error("hop index beyond the fourth dimension");

endmodule

// ===== hdl/dor4_divmod.sv =====
module dor4_divmod #(
  parameter int NODE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [NODE_BITS-1:0]             x_i,
  input  logic [dor4_pkg::RECIP_W-1:0]     recip_i,
  input  logic [dor4_pkg::POW_W-1:0]       mod_i,
  output logic [NODE_BITS-1:0]             rem_o
);

  localparam int PROD_W = NODE_BITS + dor4_pkg::RECIP_W;
  localparam int BACK_W = NODE_BITS + dor4_pkg::POW_W;

  logic [PROD_W-1:0]    prod;
  logic [BACK_W-1:0]    back;
  logic [NODE_BITS-1:0] x1_r, q1_r, r2_r, r3_r;
  logic [NODE_BITS-1:0] r2_nxt, r3_nxt;

  // The truncated reciprocal gives a quotient that is exact or one short, so
  // the partial remainder stays below twice the modulus.
  assign prod   = PROD_W'(x_i) * PROD_W'(recip_i);
  assign back   = BACK_W'(q1_r) * BACK_W'(mod_i);
  assign r2_nxt = x1_r - back[NODE_BITS-1:0];
  assign r3_nxt = (dor4_pkg::POW_W'(r2_r) >= mod_i) ? r2_r - mod_i[NODE_BITS-1:0] : r2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= x_i;
      q1_r <= prod[dor4_pkg::RECIP_SHIFT +: NODE_BITS];
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
    end
  end

  assign rem_o = r3_r;

endmodule

// ===== hdl/dor4_serial.sv =====
module dor4_serial #(
  parameter int NODE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dor4_pkg::route_ctl_t   ctl_i,
  input  logic [NODE_BITS-1:0]   nodes_i [dor4_pkg::MAX_HOPS],
  output logic                   ready_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dor4_pkg::route_hop_t   out_data
);

  localparam int HOPS = dor4_pkg::MAX_HOPS;
  localparam int SEL_W = $clog2(HOPS);

  logic                          ser_valid_r, ser_valid_nxt;
  logic [HOPS-1:0]               ser_mask_r, ser_mask_nxt;
  logic                          ser_bad_r;
  logic [dor4_pkg::IDX_W-1:0]    ser_idx_r;
  logic [NODE_BITS-1:0]          ser_node_r [HOPS];
  logic                          out_valid_r, out_valid_nxt;
  dor4_pkg::route_hop_t          out_data_r, hop_nxt;

  logic [SEL_W-1:0] sel;
  logic [HOPS-1:0]  rest;
  logic             is_last, out_load, take;

  always_comb begin
    sel = '0;
    for (int i = HOPS - 1; i >= 0; i--) begin
      if (ser_mask_r[i]) begin
        sel = SEL_W'(i);
      end
    end
    rest    = ser_mask_r & ~(HOPS'(1) << sel);
    is_last = ser_bad_r || (rest == '0);
  end

  assign out_load = ser_valid_r && (!out_valid_r || out_ready);
  assign ready_o  = !ser_valid_r || (out_load && is_last);
  assign take     = ctl_i.valid && ready_o;

  always_comb begin
    hop_nxt.hop_node  = ser_bad_r ? '0 : dor4_pkg::ID_W'(ser_node_r[sel]);
    hop_nxt.hop_index = ser_idx_r;
    hop_nxt.last_hop  = is_last;
    hop_nxt.bad_id    = ser_bad_r;
  end

  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_mask_nxt  = ser_mask_r;
    if (take) begin
      ser_valid_nxt = 1'b1;
      ser_mask_nxt  = ctl_i.bad ? HOPS'(1) : ctl_i.hops;
    end else if (out_load) begin
      ser_valid_nxt = !is_last;
      ser_mask_nxt  = rest;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ser_mask_r <= ser_mask_nxt;
    if (take) begin
      ser_bad_r  <= ctl_i.bad;
      ser_idx_r  <= '0;
      ser_node_r <= nodes_i;
    end else if (out_load) begin
      ser_idx_r <= ser_idx_r + dor4_pkg::IDX_W'(1);
    end
    if (out_load) begin
      out_data_r <= hop_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/dimension_order_route_4d_unit_checker.sv =====
`timescale 1ns / 100ps

module dimension_order_route_4d_unit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  dor4_pkg::route_req_t          in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  dor4_pkg::route_hop_t          out_data,
  input  logic                          cfg_wr_en,
  input  logic [dor4_pkg::SIDE_W-1:0]   cfg_wr_data,
  output int                            mismatch_count,
  output int                            hops_pending
);

  logic [dor4_pkg::SIDE_W-1:0] side_reg;
  dor4_pkg::route_hop_t        hops_due[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Works out the path for one request under the current side length and
  // queues one expected beat per path entry.
  function automatic void push_route_hops(input dor4_pkg::route_req_t req);
    int unsigned side;
    int unsigned total;
    int unsigned s_id;
    int unsigned d_id;
    int unsigned src_dig[4];
    int unsigned dst_dig[4];
    int unsigned walk[4];
    int unsigned path[dor4_pkg::MAX_HOPS];
    int          n;
    dor4_pkg::route_hop_t hop;

    side = side_reg;
    if (side < 2) begin
      side = 2;
    end else if (side > 16) begin
      side = 16;
    end
    total = side * side * side * side;
    s_id  = req.source_node;
    d_id  = req.dest_node;

    if (s_id >= total || d_id >= total) begin
      hop.hop_node  = '0;
      hop.hop_index = '0;
      hop.last_hop  = 1'b1;
      hop.bad_id    = 1'b1;
      hops_due = {hops_due, hop};
      return;
    end

    // Digit 0 is X, the most significant.
    for (int i = 3; i >= 0; i--) begin
      src_dig[i] = s_id % side;
      dst_dig[i] = d_id % side;
      s_id = s_id / side;
      d_id = d_id / side;
    end

    walk    = src_dig;
    path[0] = req.source_node;
    n       = 1;
    for (int i = 0; i < 4; i++) begin
      if (walk[i] != dst_dig[i]) begin
        walk[i] = dst_dig[i];
        path[n] = ((walk[0] * side + walk[1]) * side + walk[2]) * side + walk[3];
        n++;
      end
    end

    for (int k = 0; k < n; k++) begin
      hop.hop_node  = dor4_pkg::ID_W'(path[k]);
      hop.hop_index = dor4_pkg::IDX_W'(k);
      hop.last_hop  = (k == n - 1);
      hop.bad_id    = 1'b0;
      hops_due = {hops_due, hop};
    end
  endfunction

  task automatic check_hop(input dor4_pkg::route_hop_t got);
    dor4_pkg::route_hop_t want;
    if (hops_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat node %0d index %0d", got.hop_node,
                                got.hop_index));
      return;
    end
    want = hops_due.pop_front();
    if (got.hop_node !== want.hop_node) begin
      report_mismatch($sformatf("hop_node got %0d expected %0d (index %0d)",
                                got.hop_node, want.hop_node, want.hop_index));
    end
    if (got.hop_index !== want.hop_index) begin
      report_mismatch($sformatf("hop_index got %0d expected %0d (node %0d)",
                                got.hop_index, want.hop_index, want.hop_node));
    end
    if (got.last_hop !== want.last_hop) begin
      report_mismatch($sformatf("last_hop got %b expected %b (node %0d)",
                                got.last_hop, want.last_hop, want.hop_node));
    end
    if (got.bad_id !== want.bad_id) begin
      report_mismatch($sformatf("bad_id got %b expected %b (node %0d)",
                                got.bad_id, want.bad_id, want.hop_node));
    end
  endtask

  // Inputs are sampled as they stood before the edge, so a beat accepted here
  // is predicted with the side length that was in force when it was offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      side_reg <= dor4_pkg::SIDE_RESET;
      hops_due.delete();
      hops_pending <= 0;
    end else begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end
      if (out_valid && out_ready) begin
        check_hop(out_data);
      end
      if (in_valid && in_ready) begin
        push_route_hops(in_data);
      end
      if (cfg_wr_en) begin
        side_reg <= cfg_wr_data;
      end
      hops_pending <= hops_due.size();
    end
  end

endmodule

// ===== tb/sv/dimension_order_route_4d_unit_tb.sv =====
`timescale 1ns / 100ps

module dimension_order_route_4d_unit_tb;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 20;
  localparam int PHASE_ITEMS  = 30;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  dor4_pkg::route_req_t        in_data;
  logic                        out_valid;
  logic                        out_ready;
  dor4_pkg::route_hop_t        out_data;
  logic                        cfg_wr_en;
  logic [dor4_pkg::SIDE_W-1:0] cfg_wr_data;

  int mismatch_count;
  int hops_pending;
  int idle_cycles;
  bit steady;
  bit hold_request;

  dimension_order_route_4d_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dimension_order_route_4d_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .hops_pending  (hops_pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a single long hold-off counted here
  // once the stimulus asks for one.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_route(input logic [dor4_pkg::ID_W-1:0] src,
                            input logic [dor4_pkg::ID_W-1:0] dst);
    if (!steady && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_valid          <= 1'b1;
    in_data.source_node <= src;
    in_data.dest_node   <= dst;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering beats and waits until every predicted hop has come back.
  task automatic drain_routes();
    in_valid <= 1'b0;
    do @(posedge clk); while (hops_pending != 0);
  endtask

  task automatic write_side(input logic [dor4_pkg::SIDE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [dor4_pkg::SIDE_W-1:0] side_plan[12];
    int side_eff;
    int total;
    int src;
    int dst;
    int kind;
    int weight;
    int digit;
    int new_digit;

    side_plan = '{5'd6, 5'd2, 5'd3, 5'd16, 5'd31, 5'd0, 5'd7, 5'd10, 5'd1, 5'd17,
                  5'd4, 5'd13};
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    steady       = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset side length of 6: 1296 nodes.
    send_route(16'd0, 16'd0);
    send_route(16'd1295, 16'd1295);
    send_route(16'd0, 16'd1295);
    send_route(16'd1295, 16'd0);
    send_route(16'd0, 16'd216);
    send_route(16'd0, 16'd36);
    send_route(16'd0, 16'd6);
    send_route(16'd0, 16'd1);
    send_route(16'd7, 16'd1296);
    send_route(16'd1296, 16'd7);
    send_route(16'hFFFF, 16'hFFFF);
    send_route(16'hFFFF, 16'd0);
    drain_routes();

    write_side(5'd2);
    send_route(16'd0, 16'd15);
    send_route(16'd15, 16'd0);
    send_route(16'd16, 16'd0);
    send_route(16'd5, 16'd10);
    drain_routes();

    write_side(5'd16);
    send_route(16'd0, 16'hFFFF);
    send_route(16'hFFFF, 16'd0);
    send_route(16'hFFFF, 16'hFFFF);
    send_route(16'h1234, 16'h4321);
    drain_routes();

    // Out-of-range settings saturate to the nearest legal side length.
    write_side(5'd0);
    send_route(16'd15, 16'd16);
    drain_routes();
    write_side(5'd31);
    send_route(16'hABCD, 16'h0123);
    drain_routes();

    for (int phase = 0; phase < 12; phase++) begin
      drain_routes();
      // One phase with the receiver held off while the sender keeps pushing,
      // and a later one with no idling on either side.
      steady = (phase == 3) || (phase == 7);
      write_side(side_plan[phase]);
      side_eff = side_plan[phase];
      if (side_eff < 2) begin
        side_eff = 2;
      end else if (side_eff > 16) begin
        side_eff = 16;
      end
      total = side_eff * side_eff * side_eff * side_eff;
      if (phase == 3) begin
        hold_request <= 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(99);
        src  = $urandom_range(total - 1);
        if (kind < 12) begin
          dst = src;
        end else if (kind < 32) begin
          // Change a single digit so that one axis alone is crossed.
          weight = 1;
          repeat ($urandom_range(3)) weight = weight * side_eff;
          digit     = (src / weight) % side_eff;
          new_digit = $urandom_range(side_eff - 1);
          if (new_digit == digit) begin
            new_digit = (digit + 1) % side_eff;
          end
          dst = src + (new_digit - digit) * weight;
        end else if (kind < 42 && total < 65536) begin
          dst = $urandom_range(total - 1);
          case ($urandom_range(2))
            0: src = $urandom_range(65535, total);
            1: dst = $urandom_range(65535, total);
            default: begin
              src = $urandom_range(65535, total);
              dst = $urandom_range(65535, total);
            end
          endcase
        end else if (kind < 46) begin
          src = $urandom_range(65535);
          dst = $urandom_range(65535);
        end else begin
          dst = $urandom_range(total - 1);
        end
        send_route(dor4_pkg::ID_W'(src), dor4_pkg::ID_W'(dst));
      end
    end

    drain_routes();
    steady = 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && hops_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
